// File: rtl/prfl_pkg.sv
// Shared constants and types for the page replacement block.
package prfl_pkg;

  localparam int DEF_PAGES  = 128;
  localparam int DEF_FRAMES = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES  = 2'd2;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef struct packed {
    logic tick;
    logic hit;
    logic fault;
    logic repl;
  } prfl_inc_t;

endpackage

// File: rtl/prfl_stats.sv
// Time counter and running hit, fault and replacement totals.
module prfl_stats import prfl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  prfl_inc_t        inc_i,
  output logic [CNT_W-1:0] time_o,
  output logic [CNT_W-1:0] hits_o,
  output logic [CNT_W-1:0] faults_o,
  output logic [CNT_W-1:0] repl_o
);

  logic [CNT_W-1:0] time_q, hits_q, faults_q, repl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      hits_q   <= '0;
      faults_q <= '0;
      repl_q   <= '0;
    end else begin
      if (inc_i.tick)  time_q   <= time_q + CNT_W'(1);
      if (inc_i.hit)   hits_q   <= hits_q + CNT_W'(1);
      if (inc_i.fault) faults_q <= faults_q + CNT_W'(1);
      if (inc_i.repl)  repl_q   <= repl_q + CNT_W'(1);
    end
  end

  assign time_o   = time_q;
  assign hits_o   = hits_q;
  assign faults_o = faults_q;
  assign repl_o   = repl_q;

endmodule

// File: rtl/page_replacement_fifo_lru.sv
// Page replacement unit with FIFO or LRU victim choice, one page reference per beat.
// One reference is in flight at a time. A bad page goes from acceptance straight to
// S_DONE and a hit passes through S_LOOKUP first. A miss scans the active frames one
// per cycle through the frame memory read port, stopping at the first free frame, then
// passes S_VICTIM, S_EVICT if the frame is occupied, and S_COMMIT. In FIFO mode a full
// scan first reads the FIFO through S_POP and S_POPW. The next reference is accepted
// as soon as the result is in the output register.
module page_replacement_fifo_lru import prfl_pkg::*; #(
  parameter int PAGES  = DEF_PAGES,
  parameter int FRAMES = DEF_FRAMES,
  localparam int PW = $clog2(PAGES),
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PW-1:0]         page_ref_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic                  bad_page_o,
  output logic [FW-1:0]         frame_used_o,
  output logic                  evicted_o,
  output logic [PW-1:0]         evicted_page_o,
  output logic [CNT_W-1:0]      hit_count_o,
  output logic [CNT_W-1:0]      fault_count_o,
  output logic [CNT_W-1:0]      replace_count_o
);

  localparam int CW  = (FW + 1 > 7) ? FW + 1 : 7;
  localparam int PCW = (PW + 1 > 8) ? PW + 1 : 8;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_SCAN, S_POP, S_POPW, S_VICTIM, S_EVICT, S_COMMIT, S_DONE
  } state_e;

  state_e state_q;

  logic          mode_q;
  logic [6:0]    frames_q;
  logic [7:0]    pages_q;

  logic [PAGES-1:0]  present_q;
  logic [FRAMES-1:0] occ_q;

  logic [PW-1:0] page_q;
  logic [FW-1:0] victim_q;
  logic [FW-1:0] rd_idx_q, cmp_idx_q, best_idx_q;
  logic          iss_q, cmp_valid_q, cmp_last_q;
  logic [CNT_W-1:0] best_t_q;
  logic [FW-1:0] head_q, tail_q;
  logic [FW:0]   fill_q;

  logic          res_hit_q, res_bad_q, res_ev_q;
  logic [FW-1:0] res_frame_q;
  logic [PW-1:0] res_evp_q;

  logic          out_valid_q, out_hit_q, out_bad_q, out_ev_q;
  logic [FW-1:0] out_frame_q;
  logic [PW-1:0] out_evp_q;
  logic [CNT_W-1:0] out_hits_q, out_faults_q, out_repl_q;

  // Memories and their registered read data.
  logic [FW-1:0]    page_mem [PAGES];
  logic [PW-1:0]    own_mem  [FRAMES];
  logic [CNT_W-1:0] lru_mem  [FRAMES];
  logic [FW-1:0]    fifo_mem [FRAMES];
  logic [FW-1:0]    pg_rd_q, fifo_rd_q;
  logic [PW-1:0]    own_rd_q;
  logic [CNT_W-1:0] lru_rd_q;

  logic [CNT_W-1:0] time_w, hits_w, faults_w, repl_w;
  prfl_inc_t        inc;

  logic          accept, out_beat, out_free;
  logic          bad_in, is_present, cmp_free, better, scan_end;
  logic [CW-1:0] fr_ext, nf;
  logic [FW-1:0] last_idx, fr_addr, lru_waddr, new_best;
  logic [PW-1:0] pg_raddr;
  logic          pg_we, own_we, lru_we, fifo_we;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_beat    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign bad_in = PCW'(page_ref_i) >= PCW'(pages_q);

  // Active frame count clamps to 1 .. FRAMES.
  assign fr_ext = CW'(frames_q);
  always_comb begin
    if (fr_ext == '0) begin
      nf = CW'(1);
    end else if (fr_ext > CW'(FRAMES)) begin
      nf = CW'(FRAMES);
    end else begin
      nf = fr_ext;
    end
  end
  assign last_idx = FW'(nf - CW'(1));

  assign is_present = present_q[page_q];
  assign cmp_free   = !occ_q[cmp_idx_q];
  assign better     = (cmp_idx_q == '0) || (lru_rd_q < best_t_q);
  assign new_best   = better ? cmp_idx_q : best_idx_q;
  assign scan_end   = cmp_valid_q && cmp_last_q;

  assign pg_raddr  = (state_q == S_IDLE) ? page_ref_i : page_q;
  assign fr_addr   = (state_q == S_SCAN) ? rd_idx_q : victim_q;
  assign pg_we     = (state_q == S_COMMIT);
  assign own_we    = (state_q == S_COMMIT);
  assign lru_we    = (state_q == S_COMMIT) || (state_q == S_LOOKUP && is_present);
  assign lru_waddr = (state_q == S_COMMIT) ? victim_q : pg_rd_q;
  assign fifo_we   = (state_q == S_COMMIT) && (mode_q == MODE_FIFO)
                     && (fill_q != (FW + 1)'(FRAMES));

  always_comb begin
    inc       = '0;
    inc.tick  = accept;
    inc.hit   = (state_q == S_LOOKUP) && is_present;
    inc.fault = (accept && bad_in) || ((state_q == S_LOOKUP) && !is_present);
    inc.repl  = (state_q == S_EVICT);
  end

  prfl_stats u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .inc_i    (inc),
    .time_o   (time_w),
    .hits_o   (hits_w),
    .faults_o (faults_w),
    .repl_o   (repl_w)
  );

  always_ff @(posedge clk_i) begin
    if (pg_we) page_mem[page_q] <= victim_q;
    pg_rd_q <= page_mem[pg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[victim_q] <= page_q;
    if (lru_we) lru_mem[lru_waddr] <= time_w;
    own_rd_q <= own_mem[fr_addr];
    lru_rd_q <= lru_mem[fr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[tail_q] <= victim_q;
    fifo_rd_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FIFO;
      frames_q    <= 7'd64;
      pages_q     <= 8'd128;
      present_q   <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      iss_q       <= 1'b0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MODE:   mode_q   <= cfg_data_i[0];
          REG_FRAMES: frames_q <= cfg_data_i[6:0];
          REG_PAGES:  pages_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // A new result in S_DONE takes the place of the beat leaving this cycle.
      if (out_beat && (state_q != S_DONE)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            page_q      <= page_ref_i;
            res_hit_q   <= 1'b0;
            res_bad_q   <= bad_in;
            res_frame_q <= '0;
            res_ev_q    <= 1'b0;
            res_evp_q   <= '0;
            state_q     <= bad_in ? S_DONE : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (is_present) begin
            res_hit_q   <= 1'b1;
            res_frame_q <= pg_rd_q;
            state_q     <= S_DONE;
          end else begin
            rd_idx_q    <= '0;
            iss_q       <= 1'b1;
            cmp_valid_q <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one frame read per cycle; compare the frame read in the previous cycle.
          cmp_idx_q   <= rd_idx_q;
          cmp_last_q  <= (rd_idx_q == last_idx);
          rd_idx_q    <= rd_idx_q + FW'(1);
          if (cmp_valid_q) begin
            best_idx_q <= new_best;
            best_t_q   <= better ? lru_rd_q : best_t_q;
          end
          if (cmp_valid_q && cmp_free) begin
            victim_q    <= cmp_idx_q;
            iss_q       <= 1'b0;
            cmp_valid_q <= 1'b0;
            state_q     <= S_VICTIM;
          end else begin
            cmp_valid_q <= iss_q;
            iss_q       <= iss_q && (rd_idx_q != last_idx);
            if (scan_end) begin
              if (mode_q == MODE_LRU) begin
                victim_q <= new_best;
                state_q  <= S_VICTIM;
              end else begin
                state_q  <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          if (fill_q == '0) begin
            victim_q <= '0;
            state_q  <= S_VICTIM;
          end else begin
            state_q  <= S_POPW;
          end
        end
        S_POPW: begin
          victim_q <= fifo_rd_q;
          head_q   <= (head_q == FW'(FRAMES - 1)) ? '0 : head_q + FW'(1);
          fill_q   <= fill_q - (FW + 1)'(1);
          state_q  <= S_VICTIM;
        end
        S_VICTIM: begin
          state_q <= occ_q[victim_q] ? S_EVICT : S_COMMIT;
        end
        S_EVICT: begin
          present_q[own_rd_q] <= 1'b0;
          res_ev_q            <= 1'b1;
          res_evp_q           <= own_rd_q;
          state_q             <= S_COMMIT;
        end
        S_COMMIT: begin
          occ_q[victim_q]   <= 1'b1;
          present_q[page_q] <= 1'b1;
          res_frame_q       <= victim_q;
          if (fifo_we) begin
            tail_q <= (tail_q == FW'(FRAMES - 1)) ? '0 : tail_q + FW'(1);
            fill_q <= fill_q + (FW + 1)'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_hit_q    <= res_hit_q;
            out_bad_q    <= res_bad_q;
            out_frame_q  <= res_frame_q;
            out_ev_q     <= res_ev_q;
            out_evp_q    <= res_evp_q;
            out_hits_q   <= hits_w;
            out_faults_q <= faults_w;
            out_repl_q   <= repl_w;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign bad_page_o      = out_bad_q;
  assign frame_used_o    = out_frame_q;
  assign evicted_o       = out_ev_q;
  assign evicted_page_o  = out_evp_q;
  assign hit_count_o     = out_hits_q;
  assign fault_count_o   = out_faults_q;
  assign replace_count_o = out_repl_q;

endmodule

// File: rtl/prfl_checker.sv
// Port-level checks for the page replacement block, bound to the top level.
module prfl_checker import prfl_pkg::*; #(
  parameter int PW = 7,
  parameter int FW = 6
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             hit_o,
  input logic             bad_page_o,
  input logic             evicted_o,
  input logic [PW-1:0]    evicted_page_o,
  input logic [CNT_W-1:0] hit_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_count_o))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second reference accepted while one is in flight");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o && !bad_page_o)
    else $error("eviction reported on a hit or bad page");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_page_o == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind page_replacement_fifo_lru prfl_checker #(.PW(PW), .FW(FW)) u_prfl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .bad_page_o     (bad_page_o),
  .evicted_o      (evicted_o),
  .evicted_page_o (evicted_page_o),
  .hit_count_o    (hit_count_o)
);
